### hw/rtl/aiffp_pkg.sv
// ----------------------------------------------------------------------------
// aiffp_pkg
// shared result and byte types, result kinds, error codes and chunk tags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aiffp_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_FORM   = 3'd1;
    localparam logic [2:0] ERR_NO_COMM   = 3'd2;
    localparam logic [2:0] ERR_BAD_COMP  = 3'd3;
    localparam logic [2:0] ERR_SHORT     = 3'd4;
    localparam logic [2:0] ERR_BAD_SIZE  = 3'd5;
    localparam logic [2:0] ERR_NO_SSND   = 3'd6;
    localparam logic [2:0] ERR_TRUNC     = 3'd7;

    // four-character chunk tags
    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_AIFC = 32'h41494643;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;
    localparam logic [31:0] TAG_NONE = 32'h4E4F4E45;
    localparam logic [31:0] TAG_SOWT = 32'h736F7774;

    // extended float exponent of a value whose mantissa is an integer
    localparam logic [14:0] EXP_INT  = 15'd16446;
    localparam logic [14:0] EXP_MAX  = 15'h7FFF;

    localparam int PAY_W = 51;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] channels;
        logic [31:0] frames;
        logic [5:0]  sample_bits;
        logic        little_endian;
        logic [31:0] sample_rate;
        logic [2:0]  error_code;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } res_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_t;

endpackage

### hw/rtl/aiffp_in_q.sv
// ----------------------------------------------------------------------------
// aiffp_in_q
// two-entry input queue holding file bytes ahead of the parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aiffp_in_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aiffp_pkg::byte_t wr_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output aiffp_pkg::byte_t rd_item
);
    import aiffp_pkg::*;

    byte_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = count_reg[1];
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

### hw/rtl/aiffp_out_q.sv
// ----------------------------------------------------------------------------
// aiffp_out_q
// two-entry result queue between the parser and the result port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aiffp_out_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aiffp_pkg::res_t wr_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output aiffp_pkg::res_t rd_item
);
    import aiffp_pkg::*;

    res_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign full    = count_reg[1];
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

### hw/rtl/aiffp_core.sv
// ----------------------------------------------------------------------------
// aiffp_core
// chunk walker: one byte per fire, at most one result per byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aiffp_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  aiffp_pkg::byte_t item,
    output logic            res_valid,
    output aiffp_pkg::res_t res
);
    import aiffp_pkg::*;

    typedef enum logic [15:0] {
        PH_TOP_ID    = 16'h0001,
        PH_TOP_LEN   = 16'h0002,
        PH_TOP_SKIP  = 16'h0004,
        PH_FORM_LEN  = 16'h0008,
        PH_FORM_TYPE = 16'h0010,
        PH_SUB_ID    = 16'h0020,
        PH_SUB_LEN   = 16'h0040,
        PH_SUB_SKIP  = 16'h0080,
        PH_COMM_LEN  = 16'h0100,
        PH_COMM_BODY = 16'h0200,
        PH_SSND_LEN  = 16'h0400,
        PH_SSND_HDR  = 16'h0800,
        PH_SSND_OFF  = 16'h1000,
        PH_PAYLOAD   = 16'h2000,
        PH_DONE      = 16'h4000,
        PH_ERROR     = 16'h8000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [31:0]      shift_reg, shift_next;
    logic [4:0]       idx_reg, idx_next;
    logic [32:0]      chunk_reg, chunk_next;
    logic [32:0]      form_reg, form_next;
    logic             aifc_reg, aifc_next;
    logic             seen_reg, seen_next;
    logic [15:0]      chan_reg, chan_next;
    logic [31:0]      frm_reg, frm_next;
    logic [15:0]      bps_reg, bps_next;
    logic [15:0]      exp_reg, exp_next;
    logic [63:0]      mant_reg, mant_next;
    logic             swap_reg, swap_next;
    logic [PAY_W-1:0] pay_reg, pay_next;

    // derived values, recomputed every cycle from the stable comm fields
    logic [47:0]      prod_reg;
    logic [PAY_W-1:0] len_reg;
    logic [31:0]      rate_reg, rate_comb;

    logic [7:0]  b;
    logic [31:0] sh_new;
    logic        g_done;
    logic [4:0]  idx_inc;

    assign b       = item.data_byte;
    assign sh_new  = {shift_reg[23:0], b};
    assign idx_inc = idx_reg + 5'd1;
    assign g_done  = (idx_reg >= 5'd3);

    // integer part of the extended sample rate
    always_comb
    begin
        logic [14:0] e;
        logic [14:0] sh;
        logic [14:0] r;
        logic [63:0] v;
        e = exp_reg[14:0];
        sh = e - EXP_INT;
        r = EXP_INT - e;
        v = 64'd0;
        rate_comb = 32'd0;
        if (exp_reg[15])
        begin
            rate_comb = 32'd0;
        end
        else if (e == EXP_MAX)
        begin
            rate_comb = 32'hFFFFFFFF;
        end
        else if (mant_reg == 64'd0)
        begin
            rate_comb = 32'd0;
        end
        else if (e >= EXP_INT)
        begin
            if (sh >= 15'd32)
            begin
                rate_comb = 32'hFFFFFFFF;
            end
            else if ((mant_reg >> (6'd32 - sh[5:0])) != 64'd0)
            begin
                rate_comb = 32'hFFFFFFFF;
            end
            else
            begin
                v = mant_reg << sh[4:0];
                rate_comb = v[31:0];
            end
        end
        else
        begin
            if (r >= 15'd64)
            begin
                rate_comb = 32'd0;
            end
            else
            begin
                v = mant_reg >> r[5:0];
                rate_comb = (v[63:32] != 32'd0) ? 32'hFFFFFFFF : v[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [2:0] nb;
        nb = bps_reg[5:3];
        prod_reg <= frm_reg * chan_reg;
        len_reg  <= ({3'd0, prod_reg} & {PAY_W{nb[0]}})
                  + ({2'd0, prod_reg, 1'b0} & {PAY_W{nb[1]}})
                  + ({1'b0, prod_reg, 2'b0} & {PAY_W{nb[2]}});
        rate_reg <= rate_comb;
    end

    always_comb
    begin
        logic [4:0] last_k;
        logic [32:0] p;
        logic [2:0] code;
        phase_next = phase_reg;
        shift_next = shift_reg;
        idx_next   = idx_reg;
        chunk_next = chunk_reg;
        form_next  = form_reg;
        aifc_next  = aifc_reg;
        seen_next  = seen_reg;
        chan_next  = chan_reg;
        frm_next   = frm_reg;
        bps_next   = bps_reg;
        exp_next   = exp_reg;
        mant_next  = mant_reg;
        swap_next  = swap_reg;
        pay_next   = pay_reg;
        res_valid  = 1'b0;
        res        = '0;
        last_k     = aifc_reg ? 5'd21 : 5'd17;
        p          = 33'd0;
        code       = ERR_NONE;

        // form byte count runs down inside the form
        if ((phase_reg == PH_SUB_ID || phase_reg == PH_SUB_LEN || phase_reg == PH_SUB_SKIP
             || phase_reg == PH_COMM_LEN || phase_reg == PH_COMM_BODY
             || phase_reg == PH_SSND_LEN || phase_reg == PH_SSND_HDR
             || phase_reg == PH_SSND_OFF) && form_reg != 33'd0)
        begin
            form_next = form_reg - 33'd1;
        end

        case (phase_reg)
            PH_TOP_ID, PH_TOP_LEN, PH_FORM_LEN, PH_FORM_TYPE, PH_SUB_ID, PH_SUB_LEN,
            PH_COMM_LEN, PH_SSND_LEN:
            begin
                shift_next = sh_new;
                idx_next   = g_done ? 5'd0 : idx_inc;
            end
            default:
            begin
            end
        endcase

        case (phase_reg)
            PH_TOP_ID:
            begin
                if (g_done)
                begin
                    phase_next = (sh_new == TAG_FORM) ? PH_FORM_LEN : PH_TOP_LEN;
                end
            end
            PH_TOP_LEN:
            begin
                if (g_done)
                begin
                    chunk_next = {1'b0, sh_new} + {32'd0, sh_new[0]};
                    phase_next = (chunk_next != 33'd0) ? PH_TOP_SKIP : PH_TOP_ID;
                end
            end
            PH_TOP_SKIP:
            begin
                if (chunk_reg != 33'd0)
                begin
                    chunk_next = chunk_reg - 33'd1;
                end
                if (chunk_next == 33'd0)
                begin
                    phase_next = PH_TOP_ID;
                    idx_next   = 5'd0;
                end
            end
            PH_FORM_LEN:
            begin
                if (g_done)
                begin
                    form_next  = {1'b0, sh_new};
                    phase_next = PH_FORM_TYPE;
                end
            end
            PH_FORM_TYPE:
            begin
                if (g_done)
                begin
                    if (sh_new == TAG_AIFF || sh_new == TAG_AIFC)
                    begin
                        aifc_next = (sh_new == TAG_AIFC);
                        form_next = (form_reg >= 33'd4) ? form_reg - 33'd4 : 33'd0;
                        idx_next  = 5'd0;
                        if (form_next == 33'd0)
                        begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = seen_reg ? ERR_NO_SSND : ERR_NO_COMM;
                        end
                        else
                        begin
                            phase_next = PH_SUB_ID;
                        end
                    end
                    else
                    begin
                        p = {1'b0, form_reg[31:0]} + {32'd0, form_reg[0]};
                        chunk_next = (p >= 33'd4) ? p - 33'd4 : 33'd0;
                        phase_next = (chunk_next != 33'd0) ? PH_TOP_SKIP : PH_TOP_ID;
                    end
                end
            end
            PH_SUB_ID:
            begin
                if (g_done)
                begin
                    if (!seen_reg && sh_new == TAG_COMM)
                    begin
                        phase_next = PH_COMM_LEN;
                    end
                    else if (seen_reg && sh_new == TAG_SSND)
                    begin
                        phase_next = PH_SSND_LEN;
                    end
                    else
                    begin
                        phase_next = PH_SUB_LEN;
                    end
                end
            end
            PH_SUB_LEN, PH_SUB_SKIP:
            begin
                if (phase_reg == PH_SUB_LEN)
                begin
                    if (g_done)
                    begin
                        chunk_next = {1'b0, sh_new} + {32'd0, sh_new[0]};
                        phase_next = PH_SUB_SKIP;
                    end
                end
                else if (chunk_reg != 33'd0)
                begin
                    chunk_next = chunk_reg - 33'd1;
                end
                if ((phase_reg == PH_SUB_SKIP || g_done) && chunk_next == 33'd0)
                begin
                    idx_next = 5'd0;
                    if (form_next == 33'd0)
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = seen_reg ? ERR_NO_SSND : ERR_NO_COMM;
                    end
                    else
                    begin
                        phase_next = PH_SUB_ID;
                    end
                end
            end
            PH_COMM_LEN:
            begin
                if (g_done)
                begin
                    if (sh_new < 32'd18 || (aifc_reg && sh_new < 32'd22))
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SHORT;
                    end
                    else
                    begin
                        chunk_next = {1'b0, sh_new} + {32'd0, sh_new[0]};
                        phase_next = PH_COMM_BODY;
                    end
                end
            end
            PH_COMM_BODY:
            begin
                if (chunk_reg != 33'd0)
                begin
                    chunk_next = chunk_reg - 33'd1;
                end
                if (idx_reg < 5'd2)
                begin
                    chan_next = {chan_reg[7:0], b};
                end
                else if (idx_reg < 5'd6)
                begin
                    frm_next = {frm_reg[23:0], b};
                end
                else if (idx_reg < 5'd8)
                begin
                    bps_next = {bps_reg[7:0], b};
                end
                else if (idx_reg < 5'd10)
                begin
                    exp_next = {exp_reg[7:0], b};
                end
                else if (idx_reg < 5'd18)
                begin
                    mant_next = {mant_reg[55:0], b};
                end
                else
                begin
                    shift_next = sh_new;
                end
                idx_next = idx_inc;
                if (idx_reg >= last_k)
                begin
                    idx_next  = 5'd0;
                    swap_next = 1'b0;
                    if (aifc_reg && shift_next == TAG_SOWT)
                    begin
                        swap_next = 1'b1;
                    end
                    if (aifc_reg && shift_next != TAG_SOWT && shift_next != TAG_NONE)
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_COMP;
                    end
                    else if (bps_reg != 16'd8 && bps_reg != 16'd16
                             && bps_reg != 16'd24 && bps_reg != 16'd32)
                    begin
                        phase_next     = PH_ERROR;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_SIZE;
                    end
                    else
                    begin
                        seen_next = 1'b1;
                        if (chunk_next != 33'd0)
                        begin
                            phase_next = PH_SUB_SKIP;
                        end
                        else if (form_next == 33'd0)
                        begin
                            phase_next     = PH_ERROR;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NO_SSND;
                        end
                        else
                        begin
                            phase_next = PH_SUB_ID;
                        end
                    end
                end
            end
            PH_SSND_LEN:
            begin
                if (g_done)
                begin
                    chunk_next = {1'b0, sh_new} + {32'd0, sh_new[0]};
                    phase_next = PH_SSND_HDR;
                end
            end
            PH_SSND_HDR, PH_SSND_OFF:
            begin
                if (phase_reg == PH_SSND_HDR)
                begin
                    if (idx_reg < 5'd4)
                    begin
                        shift_next = sh_new;
                    end
                    idx_next = idx_inc;
                    if (idx_reg >= 5'd7)
                    begin
                        idx_next   = 5'd0;
                        chunk_next = {1'b0, shift_next};
                        phase_next = PH_SSND_OFF;
                    end
                end
                else if (chunk_reg != 33'd0)
                begin
                    chunk_next = chunk_reg - 33'd1;
                end
                if ((phase_reg == PH_SSND_OFF || idx_reg >= 5'd7) && chunk_next == 33'd0)
                begin
                    pay_next          = len_reg;
                    phase_next        = (len_reg != '0) ? PH_PAYLOAD : PH_DONE;
                    res_valid         = 1'b1;
                    res.kind          = KIND_HEADER;
                    res.channels      = chan_reg;
                    res.frames        = frm_reg;
                    res.sample_bits   = bps_reg[5:0];
                    res.little_endian = swap_reg;
                    res.sample_rate   = rate_reg;
                end
            end
            PH_PAYLOAD:
            begin
                if (pay_reg != '0)
                begin
                    pay_next = pay_reg - {{(PAY_W-1){1'b0}}, 1'b1};
                end
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = b;
                res.last_payload = (pay_next == '0);
                if (pay_next == '0)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE, PH_ERROR:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        // end of file: report an unfinished parse, then start over
        if (item.end_of_stream)
        begin
            if (phase_next != PH_DONE && phase_next != PH_ERROR)
            begin
                case (phase_next)
                    PH_TOP_ID, PH_TOP_LEN, PH_TOP_SKIP, PH_FORM_LEN, PH_FORM_TYPE:
                        code = ERR_NO_FORM;
                    PH_COMM_LEN, PH_COMM_BODY:
                        code = ERR_SHORT;
                    PH_SSND_OFF, PH_PAYLOAD:
                        code = ERR_TRUNC;
                    PH_SSND_LEN, PH_SSND_HDR:
                        code = ERR_NO_SSND;
                    default:
                        code = seen_next ? ERR_NO_SSND : ERR_NO_COMM;
                endcase
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = code;
            end
            phase_next = PH_TOP_ID;
            shift_next = 32'd0;
            idx_next   = 5'd0;
            chunk_next = 33'd0;
            form_next  = 33'd0;
            aifc_next  = 1'b0;
            seen_next  = 1'b0;
            chan_next  = 16'd0;
            frm_next   = 32'd0;
            bps_next   = 16'd0;
            exp_next   = 16'd0;
            mant_next  = 64'd0;
            swap_next  = 1'b0;
            pay_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TOP_ID;
            shift_reg <= 32'd0;
            idx_reg   <= 5'd0;
            chunk_reg <= 33'd0;
            form_reg  <= 33'd0;
            aifc_reg  <= 1'b0;
            seen_reg  <= 1'b0;
            chan_reg  <= 16'd0;
            frm_reg   <= 32'd0;
            bps_reg   <= 16'd0;
            exp_reg   <= 16'd0;
            mant_reg  <= 64'd0;
            swap_reg  <= 1'b0;
            pay_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            idx_reg   <= idx_next;
            chunk_reg <= chunk_next;
            form_reg  <= form_next;
            aifc_reg  <= aifc_next;
            seen_reg  <= seen_next;
            chan_reg  <= chan_next;
            frm_reg   <= frm_next;
            bps_reg   <= bps_next;
            exp_reg   <= exp_next;
            mant_reg  <= mant_next;
            swap_reg  <= swap_next;
            pay_reg   <= pay_next;
        end
    end
endmodule

### hw/rtl/aiff_header_parser.sv
// ----------------------------------------------------------------------------
// aiff_header_parser
// streaming aiff / aifc header parser with audio byte pass-through
// ----------------------------------------------------------------------------
// The block takes one file byte per item and walks the chunk structure:
// it finds the AIFF or AIFC form, reads COMM, skips to the SSND data and
// gives one header item, then one payload item for each audio byte, the
// last one marked, or an error item. It sustains one byte per clock: a
// two-entry input queue feeds the chunk walker, which takes one byte per
// fire and writes at most one result into a two-entry result queue. The
// walker stalls only when the result queue is full. Each item is registered
// in the input queue and its result in the result queue, whose head drives
// the result ports. The payload length and sample rate are computed in
// registers behind COMM, well before SSND data.
`timescale 1ns / 1ps

module aiff_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [15:0] channels,
    output logic [31:0] frames,
    output logic [5:0]  sample_bits,
    output logic        little_endian,
    output logic [31:0] sample_rate,
    output logic [2:0]  error_code,
    output logic [7:0]  payload_byte,
    output logic        last_payload
);
    import aiffp_pkg::*;

    byte_t in_item, q_item;
    logic  q_empty;
    logic  r_full;
    logic  fire;
    logic  res_valid;
    res_t  res, out_item;

    assign in_item.data_byte     = data_byte;
    assign in_item.end_of_stream = end_of_stream;

    // front: byte queue
    aiffp_in_q u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (in_item),
        .full    (full),
        .pop     (fire),
        .empty   (q_empty),
        .rd_item (q_item)
    );

    // walker advances when a byte waits and its result has room
    assign fire = !q_empty && !r_full;

    aiffp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (q_item),
        .res_valid (res_valid),
        .res       (res)
    );

    // back: result queue
    aiffp_out_q u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fire && res_valid),
        .wr_item (res),
        .full    (r_full),
        .pop     (pop),
        .empty   (empty),
        .rd_item (out_item)
    );

    assign kind          = out_item.kind;
    assign channels      = out_item.channels;
    assign frames        = out_item.frames;
    assign sample_bits   = out_item.sample_bits;
    assign little_endian = out_item.little_endian;
    assign sample_rate   = out_item.sample_rate;
    assign error_code    = out_item.error_code;
    assign payload_byte  = out_item.payload_byte;
    assign last_payload  = out_item.last_payload;
endmodule
